@@ rtl/core/jeo_pkg.sv @@
// ----------------------------------------------------------------------------
// jeo_pkg
// shared constants, types and helpers of the josephus elimination order block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package jeo_pkg;

  localparam int unsigned MaxChildren = 64;
  localparam int unsigned SlotW  = (MaxChildren > 1) ? $clog2(MaxChildren) : 1;
  localparam int unsigned CountW = $clog2(MaxChildren + 1);
  localparam int unsigned SizeW  = 7;
  localparam int unsigned StepW  = 32;
  localparam int unsigned DivCntW = $clog2(StepW);

  typedef logic [SlotW-1:0]  slot_t;
  typedef logic [CountW-1:0] count_t;

  typedef enum logic [2:0] {
    StIdle,
    StInit,
    StDiv,
    StWalk,
    StRemove
  } jeo_state_e;

  // next slot around a circle of size members
  function automatic slot_t next_slot(input slot_t pos, input count_t size);
    logic [CountW:0] inc;
    inc = {1'b0, CountW'(pos)} + 1'b1;
    if (inc >= {1'b0, size}) begin
      next_slot = '0;
    end else begin
      next_slot = SlotW'(inc);
    end
  endfunction

endpackage

@@ rtl/core/josephus_elimination_order.sv @@
// ----------------------------------------------------------------------------
// josephus_elimination_order
// sequence: the alive memory is filled first, then per removal a bit-serial remainder,
//   a slot walk and a write-back happen before the word is offered
// runs: a new run is taken only while idle, after the last removal is written back;
//   the bit-serial remainder and the one-slot-a-cycle alive memory walk set the run length
// reset: control and output valid clear; the alive memory is refilled per run
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module josephus_elimination_order (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [jeo_pkg::SizeW-1:0]     circle_size_i,
  input  logic [jeo_pkg::StepW-1:0]     step_size_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [jeo_pkg::SizeW-1:0]     removed_position_o,
  output logic                          run_done_o
);
  import jeo_pkg::*;

  jeo_state_e state_q, state_d;

  count_t             size_q, size_d;
  count_t             left_q, left_d;
  slot_t              cur_q, cur_d;
  slot_t              init_q, init_d;
  logic [StepW-1:0]   skip_q, skip_d;
  logic [StepW-1:0]   shift_q, shift_d;
  logic [DivCntW-1:0] div_cnt_q, div_cnt_d;
  count_t             rem_q, rem_d;
  slot_t              rd_addr_q, rd_addr_d;
  slot_t              chk_addr_q, chk_addr_d;
  logic               chk_vld_q, chk_vld_d;
  slot_t              cnt_q, cnt_d;
  slot_t              pos_q, pos_d;

  logic               out_valid_q, out_valid_d;
  logic [SizeW-1:0]   out_pos_q, out_pos_d;
  logic               out_done_q, out_done_d;

  logic               mem_we;
  slot_t              mem_waddr;
  logic               mem_wdata;
  logic               rdata_q;
  logic               alive_mem [MaxChildren];

  logic               in_acc;
  logic               load_out;
  logic               found;
  count_t             size_sat;
  logic [CountW:0]    trial;
  logic [CountW:0]    init_inc;

  assign in_ready_o = (state_q == StIdle);
  assign in_acc     = in_valid_i && in_ready_o;
  assign load_out   = (state_q == StRemove) && (!out_valid_q || out_ready_i);
  assign found      = chk_vld_q && rdata_q && (CountW'(cnt_q) == rem_q);

  assign size_sat = (circle_size_i > SizeW'(MaxChildren)) ? CountW'(MaxChildren)
                                                          : CountW'(circle_size_i);
  assign trial    = {rem_q, shift_q[StepW-1]};
  assign init_inc = {1'b0, CountW'(init_q)} + 1'b1;

  always_comb begin
    state_d     = state_q;
    size_d      = size_q;
    left_d      = left_q;
    cur_d       = cur_q;
    init_d      = init_q;
    skip_d      = skip_q;
    shift_d     = shift_q;
    div_cnt_d   = div_cnt_q;
    rem_d       = rem_q;
    rd_addr_d   = rd_addr_q;
    chk_addr_d  = chk_addr_q;
    chk_vld_d   = 1'b0;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    out_pos_d   = out_pos_q;
    out_done_d  = out_done_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mem_we      = 1'b0;
    mem_waddr   = init_q;
    mem_wdata   = 1'b1;

    case (state_q)
      StIdle: begin
        if (in_acc && (size_sat != '0)) begin
          size_d  = size_sat;
          left_d  = size_sat;
          cur_d   = '0;
          init_d  = '0;
          skip_d  = step_size_i - 1'b1;
          state_d = StInit;
        end
      end
      StInit: begin
        mem_we = 1'b1;
        init_d = SlotW'(init_inc);
        if (init_inc == {1'b0, size_q}) begin
          shift_d   = skip_q;
          rem_d     = '0;
          div_cnt_d = '0;
          state_d   = StDiv;
        end
      end
      StDiv: begin
        // restoring remainder, one dividend bit a cycle
        if (trial >= {1'b0, left_q}) begin
          rem_d = CountW'(trial - {1'b0, left_q});
        end else begin
          rem_d = CountW'(trial);
        end
        shift_d   = shift_q << 1;
        div_cnt_d = div_cnt_q + 1'b1;
        if (div_cnt_q == DivCntW'(StepW - 1)) begin
          rd_addr_d = cur_q;
          cnt_d     = '0;
          state_d   = StWalk;
        end
      end
      StWalk: begin
        // reads issue every cycle, the flag of chk_addr returns in the next cycle
        rd_addr_d  = next_slot(rd_addr_q, size_q);
        chk_addr_d = rd_addr_q;
        chk_vld_d  = 1'b1;
        if (found) begin
          pos_d     = chk_addr_q;
          chk_vld_d = 1'b0;
          state_d   = StRemove;
        end else if (chk_vld_q && rdata_q) begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      StRemove: begin
        if (load_out) begin
          mem_we      = 1'b1;
          mem_waddr   = pos_q;
          mem_wdata   = 1'b0;
          out_valid_d = 1'b1;
          out_pos_d   = SizeW'(pos_q) + 1'b1;
          out_done_d  = (left_q == CountW'(1));
          left_d      = left_q - 1'b1;
          cur_d       = next_slot(pos_q, size_q);
          if (left_q == CountW'(1)) begin
            state_d = StIdle;
          end else begin
            shift_d   = skip_q;
            rem_d     = '0;
            div_cnt_d = '0;
            state_d   = StDiv;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      left_q      <= '0;
      cur_q       <= '0;
      chk_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      left_q      <= left_d;
      cur_q       <= cur_d;
      chk_vld_q   <= chk_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    size_q     <= size_d;
    init_q     <= init_d;
    skip_q     <= skip_d;
    shift_q    <= shift_d;
    div_cnt_q  <= div_cnt_d;
    rem_q      <= rem_d;
    rd_addr_q  <= rd_addr_d;
    chk_addr_q <= chk_addr_d;
    cnt_q      <= cnt_d;
    pos_q      <= pos_d;
    out_pos_q  <= out_pos_d;
    out_done_q <= out_done_d;
  end

  // alive flags, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      alive_mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= alive_mem[rd_addr_q];
  end

  assign out_valid_o        = out_valid_q;
  assign removed_position_o = out_pos_q;
  assign run_done_o         = out_done_q;

  a_walk_has_members: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWalk) |-> (left_q != '0))
    else $error("walk with empty circle");

  a_walk_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWalk) |-> (CountW'(cnt_q) <= rem_q))
    else $error("walk passed the target member");

  a_rem_below_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (rem_q < left_q))
    else $error("remainder not below members left");

  a_run_starts_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (circle_size_i != '0)) |=> (state_q == StInit))
    else $error("run did not start fill");

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// runs directed and random josephus runs through the elimination order block,
// predicts every removal word in order and compares it with what comes out
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned PosW = jeo_pkg::SizeW;
  localparam int unsigned NumDirected = 18;
  localparam int unsigned NumRandom = 100;
  localparam int unsigned LongHold = 3000;

  typedef struct packed {
    logic [PosW-1:0] position;
    logic            done;
  } removal_t;

  typedef struct packed {
    logic [jeo_pkg::SizeW-1:0] size;
    logic [jeo_pkg::StepW-1:0] step;
    logic                      typed;
    removal_t                  typed_word;
  } stim_row_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic [jeo_pkg::SizeW-1:0] circle_size_i;
  logic [jeo_pkg::StepW-1:0] step_size_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic [PosW-1:0]           removed_position_o;
  logic                      run_done_o;

  removal_t    expected_removals[$];
  int unsigned error_count = 0;
  int unsigned removals_seen = 0;

  // typed rows: empty circles give nothing, a lone member comes out as 1 and last
  stim_row_t directed_rows [NumDirected] = '{
    '{7'd0,   32'd5,         1'b1, '{7'd0, 1'b0}},
    '{7'd1,   32'd1,         1'b1, '{7'd1, 1'b1}},
    '{7'd1,   32'd0,         1'b1, '{7'd1, 1'b1}},
    '{7'd1,   32'hFFFF_FFFF, 1'b1, '{7'd1, 1'b1}},
    '{7'd2,   32'd1,         1'b0, '{7'd0, 1'b0}},
    '{7'd7,   32'd3,         1'b0, '{7'd0, 1'b0}},
    '{7'd5,   32'd0,         1'b0, '{7'd0, 1'b0}},
    '{7'd64,  32'd1,         1'b0, '{7'd0, 1'b0}},
    '{7'd64,  32'd2,         1'b0, '{7'd0, 1'b0}},
    '{7'd64,  32'hFFFF_FFFF, 1'b0, '{7'd0, 1'b0}},
    '{7'd65,  32'd3,         1'b0, '{7'd0, 1'b0}},
    '{7'd127, 32'd0,         1'b0, '{7'd0, 1'b0}},
    '{7'd0,   32'hFFFF_FFFF, 1'b1, '{7'd0, 1'b0}},
    '{7'd10,  32'd10,        1'b0, '{7'd0, 1'b0}},
    '{7'd3,   32'hAAAA_AAAA, 1'b0, '{7'd0, 1'b0}},
    '{7'd42,  32'h5555_5555, 1'b0, '{7'd0, 1'b0}},
    '{7'd85,  32'd7,         1'b0, '{7'd0, 1'b0}},
    '{7'd63,  32'd64,        1'b0, '{7'd0, 1'b0}}
  };

  josephus_elimination_order i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .circle_size_i      (circle_size_i),
    .step_size_i        (step_size_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .removed_position_o (removed_position_o),
    .run_done_o         (run_done_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // first live slot at or after from, going round the circle
  function automatic int unsigned first_live(input logic [jeo_pkg::MaxChildren-1:0] alive,
                                             input int unsigned from,
                                             input int unsigned size);
    int unsigned slot;
    slot = from;
    for (int unsigned i = 0; i < size; i++) begin
      if (alive[slot]) return slot;
      slot = (slot + 1 >= size) ? 0 : slot + 1;
    end
    return slot;
  endfunction

  function automatic void predict_removals(input logic [jeo_pkg::SizeW-1:0] size_in,
                                           input logic [jeo_pkg::StepW-1:0] step);
    logic [jeo_pkg::MaxChildren-1:0] alive;
    int unsigned size, left, skip, hops, slot, start;
    removal_t word;
    size = (size_in > jeo_pkg::MaxChildren) ? jeo_pkg::MaxChildren : size_in;
    if (size == 0) return;
    alive = '0;
    for (int unsigned i = 0; i < size; i++) alive[i] = 1'b1;
    left  = size;
    start = 0;
    // zero step wraps to all ones here
    skip  = step - 32'd1;
    while (left > 0) begin
      hops = skip % left;
      slot = first_live(alive, start, size);
      for (int unsigned i = 0; i < hops; i++) begin
        slot = first_live(alive, (slot + 1 >= size) ? 0 : slot + 1, size);
      end
      word.position = PosW'(slot + 1);
      word.done     = (left == 1);
      expected_removals.push_back(word);
      alive[slot] = 1'b0;
      left--;
      start = (slot + 1 >= size) ? 0 : slot + 1;
    end
  endfunction

  function automatic int unsigned draw_idle(input bit calm);
    return calm ? 0 : $urandom_range(0, 13);
  endfunction

  bit send_calm = 1'b0;

  task automatic offer_run(input logic [jeo_pkg::SizeW-1:0] size,
                           input logic [jeo_pkg::StepW-1:0] step,
                           input logic typed, input removal_t typed_word);
    int unsigned gap;
    if ($urandom_range(0, 15) == 0) send_calm = !send_calm;
    gap = draw_idle(send_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    circle_size_i <= size;
    step_size_i   <= step;
    in_valid_i    <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    if (typed) begin
      if (size != 0) expected_removals.push_back(typed_word);
    end else begin
      predict_removals(size, step);
    end
    @(negedge clk_i);
  endtask

  function automatic logic [jeo_pkg::SizeW-1:0] draw_size();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return '0;
    if (pick == 1) return jeo_pkg::SizeW'($urandom_range(65, 127));
    if (pick <= 3) return jeo_pkg::SizeW'($urandom_range(33, 64));
    return jeo_pkg::SizeW'($urandom_range(1, 16));
  endfunction

  function automatic logic [jeo_pkg::StepW-1:0] draw_step();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return 32'hFFFF_FFFF - $urandom_range(0, 15);
    if (pick <= 4) return $urandom;
    return $urandom_range(1, 12);
  endfunction

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    circle_size_i = '0;
    step_size_i   = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (directed_rows[i]) begin
      offer_run(directed_rows[i].size, directed_rows[i].step,
                directed_rows[i].typed, directed_rows[i].typed_word);
    end
    for (int unsigned i = 0; i < NumRandom; i++) begin
      offer_run(draw_size(), draw_step(), 1'b0, '0);
    end
    in_valid_i <= 1'b0;
    while (expected_removals.size() != 0) @(posedge clk_i);
    // wait on, so that any word beyond the expected ones is still caught
    repeat (500) @(posedge clk_i);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // receiver: random stalls per word, one long hold to back the block up
  initial begin
    int unsigned stall;
    bit          held;
    bit          calm;
    out_ready_i = 1'b0;
    held = 1'b0;
    calm = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 15) == 0) calm = !calm;
      stall = draw_idle(calm);
      if (!held && removals_seen >= 30) begin
        stall = LongHold;
        held  = 1'b1;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    removal_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      removals_seen++;
      if (expected_removals.size() == 0) begin
        $error("unexpected word: removed_position %0d run_done %0d",
               removed_position_o, run_done_o);
        error_count++;
      end else begin
        want = expected_removals.pop_front();
        if (removed_position_o !== want.position) begin
          $error("removed_position: expected %0d, actual %0d",
                 want.position, removed_position_o);
          error_count++;
        end
        if (run_done_o !== want.done) begin
          $error("run_done: expected %0d, actual %0d", want.done, run_done_o);
          error_count++;
        end
      end
    end
  end

  initial begin
    #40_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/jeo_pkg.sv
rtl/core/josephus_elimination_order.sv
tb/sv/testbench.sv
